>>> design/gcd_pkg.sv
// Shared constants, types and small functions for the great circle distance pipeline.
// Used by every cell module and by great_circle_distance_top; no dependencies.
package gcd_pkg;

	// Pipeline shape
	localparam int ROT_CELLS  = 30;
	localparam int SQRT_CELLS = 32;
	localparam int VEC_CELLS  = 30;
	localparam int LANES      = 4;
	localparam int DEPTH      = 5 + ROT_CELLS + 4 + SQRT_CELLS + VEC_CELLS + 2;

	// Coordinate bounds, degrees scaled by 65536
	localparam int signed LAT_LIM = 5898240;
	localparam int signed LON_LIM = 11796480;

	// Degrees to radians: floor(floor(pi * 2^44) / 180), split for two narrow products
	localparam logic [38:0] RADK    = 39'(48'h3243F6A8885A / 48'd180);
	localparam logic [19:0] RADK_LO = RADK[19:0];
	localparam logic [18:0] RADK_HI = RADK[38:20];

	// Q30 constants
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [32:0] INV_GAIN    = 33'd652032874;

	// Twice the Earth radius in km, and the largest distance
	localparam logic [13:0] DIAM_KM  = 14'd12742;
	localparam logic [14:0] DIST_MAX = 15'd20016;

	// Rotation CORDIC state
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} gcd_rot_t;

	// Vectoring CORDIC state
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} gcd_vec_t;

	// Digit-by-digit square root state
	typedef struct packed {
		logic [63:0] n;
		logic [63:0] r;
	} gcd_sqrt_t;

	// Per-stage control carried beside the payload
	typedef struct packed {
		logic valid;
		logic err;
	} gcd_side_t;

	// atan(2^-i) in Q30
	function automatic logic [29:0] atan_step(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0:    a = 30'd843314857;
			5'd1:    a = 30'd497837829;
			5'd2:    a = 30'd263043837;
			5'd3:    a = 30'd133525159;
			5'd4:    a = 30'd67021687;
			5'd5:    a = 30'd33543516;
			5'd6:    a = 30'd16775851;
			5'd7:    a = 30'd8388437;
			5'd8:    a = 30'd4194283;
			5'd9:    a = 30'd2097149;
			5'd10:   a = 30'd1048576;
			default: a = 30'(31'd1 << (5'd30 - i));
		endcase
		return a;
	endfunction

	// Trial bit of square root step i: 2^(62 - 2i)
	function automatic logic [63:0] sqrt_bit(input logic [4:0] i);
		logic [6:0] sh;
		sh = 7'd62 - {1'b0, i, 1'b0};
		return 64'd1 << sh;
	endfunction

endpackage

>>> design/gcd_rot_cell.sv
// One rotation-mode CORDIC step (sin/cos), registered.
// Depends on gcd_pkg for the state type and the atan table.
module gcd_rot_cell import gcd_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  logic [4:0] step,
	input  gcd_rot_t d,
	output gcd_rot_t q
);

	gcd_rot_t cell_q;
	gcd_rot_t nxt;
	logic signed [32:0] dx, dy, a;

	// Rotate toward zero residual angle
	always_comb begin
		dx = $signed(d.y) >>> step;
		dy = $signed(d.x) >>> step;
		a  = $signed({3'b000, atan_step(step)});
		if (!d.z[32]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - a;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + a;
		end
	end

	// Advance to the neighbor
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule

>>> design/gcd_sqrt_cell.sv
// One digit step of an exact integer square root, registered.
// Depends on gcd_pkg for the state type and the trial bit function.
module gcd_sqrt_cell import gcd_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  logic [4:0] step,
	input  gcd_sqrt_t d,
	output gcd_sqrt_t q
);

	gcd_sqrt_t cell_q;
	gcd_sqrt_t nxt;
	logic [63:0] b, t;

	// Try the next root bit and keep it when it fits
	always_comb begin
		b = sqrt_bit(step);
		t = d.r + b;
		if (d.n >= t) begin
			nxt.n = d.n - t;
			nxt.r = (d.r >> 1) + b;
		end else begin
			nxt.n = d.n;
			nxt.r = d.r >> 1;
		end
	end

	// Advance to the neighbor
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule

>>> design/gcd_vec_cell.sv
// One vectoring-mode CORDIC step (atan2), registered.
// Depends on gcd_pkg for the state type and the atan table.
module gcd_vec_cell import gcd_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  logic [4:0] step,
	input  gcd_vec_t d,
	output gcd_vec_t q
);

	gcd_vec_t cell_q;
	gcd_vec_t nxt;
	logic signed [33:0] dx, dy;
	logic signed [32:0] a;

	// Rotate the vector toward the x axis, accumulate the angle
	always_comb begin
		dx = $signed(d.y) >>> step;
		dy = $signed(d.x) >>> step;
		a  = $signed({3'b000, atan_step(step)});
		if (!d.y[33]) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + a;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - a;
		end
	end

	// Advance to the neighbor
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule

>>> design/great_circle_distance_top.sv
// Haversine great circle distance, fully pipelined through chains of CORDIC and root cells.
// Depends on gcd_pkg, gcd_rot_cell, gcd_sqrt_cell and gcd_vec_cell.
//
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: lat_a, lon_a, lat_b, lon_b
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: distance_km; tuser: coord_error
//
// One transaction is taken every cycle unless the pipeline stalls; data passes through the four
// 30-cell rotation chains, the two 32-cell root chains and the 30-cell atan2 chain.
// The whole pipeline advances as one: it stalls only while a result sits in the
// output register and m_axis_tready is low. arst_n clears the valid and error lines only.
module great_circle_distance_top import gcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // lat_a[23:0], lon_a[48:24], lat_b[72:49], lon_b[97:73]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata,  // distance_km[14:0]
	output logic         m_axis_tuser   // coord_error[0]
);

	logic en;
	gcd_side_t side_q [DEPTH];

	logic signed [23:0] lat_a, lat_b;
	logic signed [24:0] lon_a, lon_b;
	logic in_err;

	assign lat_a = s_axis_tdata[23:0];
	assign lon_a = s_axis_tdata[48:24];
	assign lat_b = s_axis_tdata[72:49];
	assign lon_b = s_axis_tdata[97:73];

	assign en            = !side_q[DEPTH-1].valid || m_axis_tready;
	assign s_axis_tready = en;

	// Flag any coordinate outside its inclusive bounds
	assign in_err = (lat_a < -LAT_LIM) || (lat_a > LAT_LIM) ||
	                (lat_b < -LAT_LIM) || (lat_b > LAT_LIM) ||
	                (lon_a < -LON_LIM) || (lon_a > LON_LIM) ||
	                (lon_b < -LON_LIM) || (lon_b > LON_LIM);

	// Valid and error line beside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) side_q[k] <= '0;
		end else if (en) begin
			side_q[0] <= '{valid: s_axis_tvalid, err: in_err};
			for (int k = 1; k < DEPTH; k++) side_q[k] <= side_q[k-1];
		end
	end

	// ---------------- front end: angles in Q30 ----------------
	logic signed [23:0] la_s1, lb_s1;
	logic signed [24:0] oa_s1, ob_s1;
	logic signed [25:0] sv [LANES];
	logic [25:0] mag_s2 [LANES];
	logic [45:0] lo_s3 [LANES];
	logic [44:0] hi_s3 [LANES];
	logic [65:0] sum [LANES];
	logic [32:0] ang_s4 [LANES];
	logic [32:0] z_s5 [LANES];

	// Signed values: lat a, lat b, lat difference, lon difference
	always_comb begin
		sv[0] = 26'(la_s1);
		sv[1] = 26'(lb_s1);
		sv[2] = 26'(lb_s1) - 26'(la_s1);
		sv[3] = 26'(ob_s1) - 26'(oa_s1);
		for (int k = 0; k < LANES; k++) begin
			sum[k] = ({21'd0, hi_s3[k]} << 20) + {20'd0, lo_s3[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// capture the transaction
			la_s1 <= lat_a;
			lb_s1 <= lat_b;
			oa_s1 <= lon_a;
			ob_s1 <= lon_b;
			for (int k = 0; k < LANES; k++) begin
				// magnitudes; only cos and sin^2 follow
				mag_s2[k] <= sv[k][25] ? 26'(-sv[k]) : 26'(sv[k]);
				// split product by the radian constant
				lo_s3[k]  <= {20'd0, mag_s2[k]} * {26'd0, RADK_LO};
				hi_s3[k]  <= {19'd0, mag_s2[k]} * {26'd0, RADK_HI};
			end
			// full angles for the latitudes, half angles for the differences
			ang_s4[0] <= sum[0][62:30];
			ang_s4[1] <= sum[1][62:30];
			ang_s4[2] <= sum[2][63:31];
			ang_s4[3] <= sum[3][63:31];
			// fold half differences beyond pi/2
			z_s5[0] <= ang_s4[0];
			z_s5[1] <= ang_s4[1];
			for (int k = 2; k < LANES; k++) begin
				z_s5[k] <= (ang_s4[k] > HALF_PI_Q30) ? PI_Q30 - ang_s4[k] : ang_s4[k];
			end
		end
	end

	// ---------------- sin/cos chains ----------------
	gcd_rot_t rot_w [LANES][ROT_CELLS+1];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign rot_w[l][0] = '{x: INV_GAIN, y: '0, z: z_s5[l]};
		for (genvar c = 0; c < ROT_CELLS; c++) begin : g_cell
			gcd_rot_cell u_cell (
				.clk  (clk),
				.en   (en),
				.step (5'(c)),
				.d    (rot_w[l][c]),
				.q    (rot_w[l][c+1])
			);
		end
	end

	// ---------------- haversine term ----------------
	function automatic logic [30:0] clamp01(input logic signed [32:0] v);
		if (v[32]) return '0;
		if (v > $signed({2'b00, ONE_Q30})) return ONE_Q30;
		return v[30:0];
	endfunction

	logic [30:0] c1_s36, c2_s36, sl_s36, sn_s36;
	logic [30:0] pll_s37, pcc_s37, pnn_s37;
	logic [30:0] pll_s38, p2_s38;
	logic [61:0] prod_ll, prod_cc, prod_nn, prod_2;
	logic [31:0] hsum;
	logic [30:0] h;
	gcd_sqrt_t sqs_s39, sqc_s39;

	always_comb begin
		prod_ll = {31'd0, sl_s36} * {31'd0, sl_s36};
		prod_cc = {31'd0, c1_s36} * {31'd0, c2_s36};
		prod_nn = {31'd0, sn_s36} * {31'd0, sn_s36};
		prod_2  = {31'd0, pcc_s37} * {31'd0, pnn_s37};
		hsum    = {1'b0, pll_s38} + {1'b0, p2_s38};
		h       = (hsum > {1'b0, ONE_Q30}) ? ONE_Q30 : hsum[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// clamp CORDIC outputs to [0, 1]
			c1_s36  <= clamp01(rot_w[0][ROT_CELLS].x);
			c2_s36  <= clamp01(rot_w[1][ROT_CELLS].x);
			sl_s36  <= clamp01(rot_w[2][ROT_CELLS].y);
			sn_s36  <= clamp01(rot_w[3][ROT_CELLS].y);
			// Q30 products
			pll_s37 <= prod_ll[60:30];
			pcc_s37 <= prod_cc[60:30];
			pnn_s37 <= prod_nn[60:30];
			pll_s38 <= pll_s37;
			p2_s38  <= prod_2[60:30];
			// radicands h and 1 - h, scaled by 2^30
			sqs_s39 <= '{n: {3'd0, h, 30'd0}, r: '0};
			sqc_s39 <= '{n: {3'd0, ONE_Q30 - h, 30'd0}, r: '0};
		end
	end

	// ---------------- square root chains ----------------
	gcd_sqrt_t sqs_w [SQRT_CELLS+1];
	gcd_sqrt_t sqc_w [SQRT_CELLS+1];

	assign sqs_w[0] = sqs_s39;
	assign sqc_w[0] = sqc_s39;

	for (genvar c = 0; c < SQRT_CELLS; c++) begin : g_sqrt
		gcd_sqrt_cell u_sin (
			.clk  (clk),
			.en   (en),
			.step (5'(c)),
			.d    (sqs_w[c]),
			.q    (sqs_w[c+1])
		);
		gcd_sqrt_cell u_cos (
			.clk  (clk),
			.en   (en),
			.step (5'(c)),
			.d    (sqc_w[c]),
			.q    (sqc_w[c+1])
		);
	end

	// ---------------- atan2 chain ----------------
	gcd_vec_t vec_w [VEC_CELLS+1];

	assign vec_w[0] = '{x: {3'd0, sqc_w[SQRT_CELLS].r[30:0]},
	                    y: {3'd0, sqs_w[SQRT_CELLS].r[30:0]}, z: '0};

	for (genvar c = 0; c < VEC_CELLS; c++) begin : g_vec
		gcd_vec_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (5'(c)),
			.d    (vec_w[c]),
			.q    (vec_w[c+1])
		);
	end

	// ---------------- distance ----------------
	logic [30:0] theta;
	logic [44:0] prod_s102;
	logic [14:0] dist_s103;

	assign theta = vec_w[VEC_CELLS].z[32] ? '0 : vec_w[VEC_CELLS].z[30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s102 <= {14'd0, theta} * {31'd0, DIAM_KM};
			// saturate, and drop to zero for bad coordinates
			if (side_q[DEPTH-2].err) begin
				dist_s103 <= '0;
			end else if (prod_s102[44:30] > DIST_MAX) begin
				dist_s103 <= DIST_MAX;
			end else begin
				dist_s103 <= prod_s102[44:30];
			end
		end
	end

	assign m_axis_tvalid = side_q[DEPTH-1].valid;
	assign m_axis_tdata  = {1'b0, dist_s103};
	assign m_axis_tuser  = side_q[DEPTH-1].err;

	// ---------------- checks ----------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
		else $error("coordinate error with nonzero distance");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:0] <= DIST_MAX)
		else $error("distance above the half circumference");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule
